// ----- rtl/core/sliding_window_peak_counter_top_defines.svh -----
// assertion macros for the sliding window peak counter
// used by swpc_intake and swpc_scan; no other dependencies
`ifndef SLIDING_WINDOW_PEAK_COUNTER_TOP_DEFINES_SVH
`define SLIDING_WINDOW_PEAK_COUNTER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SWPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SWPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/swpc_pkg.sv -----
// shared types, widths and helpers of the sliding window peak counter
// no dependencies; used by every module of the block
package swpc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int INDEX_W   = 16;
    localparam int WIN_MAX   = 1024;
    localparam int RING_AW   = $clog2(WIN_MAX);
    localparam int COUNT_W   = 10;
    localparam int CFG_W     = 11;
    localparam int OUT_W     = 1 + COUNT_W + INDEX_W + 1;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int S_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0]   WIN_RESET = CFG_W'(3);
    localparam logic [CFG_W-1:0]   WIN_LO    = CFG_W'(3);
    localparam logic [CFG_W-1:0]   WIN_HI    = CFG_W'(WIN_MAX);
    localparam logic [COUNT_W-1:0] COUNT_CAP = '1;
    localparam logic [INDEX_W-1:0] POS_MAX   = '1;

    // one accepted sample with its precomputed window bookkeeping
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        logic                skip;   // index range exhausted, sample ignored
        logic                full;   // a full window ends at this sample
        logic [INDEX_W-1:0]  pos;    // 1-based position of the sample
        logic [INDEX_W-1:0]  left;   // 1-based start of the window ending here
    } item_t;

    // peak flag ring write request
    typedef struct packed {
        logic               en;
        logic [RING_AW-1:0] addr;
        logic               data;
    } flag_wr_t;

    // clamp the configured window length into its legal range
    function automatic logic [CFG_W-1:0] clamp_window(input logic [CFG_W-1:0] k);
        logic [CFG_W-1:0] res;
        res = k;
        if (k < WIN_LO) begin
            res = WIN_LO;
        end else if (k > WIN_HI) begin
            res = WIN_HI;
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/swpc_flag_ring.sv -----
// ring of one-bit peak flags with registered read and write forwarding
// depends on swpc_pkg
module swpc_flag_ring (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [swpc_pkg::RING_AW-1:0] rd_addr,
    input  swpc_pkg::flag_wr_t           wr,
    output logic                         rd_data
);

    logic ring_mem [swpc_pkg::WIN_MAX];
    logic rd_data_reg;

    // write port, and read port that sees a write to the same entry
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            ring_mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            if (wr.en && (wr.addr == rd_addr)) begin
                rd_data_reg <= wr.data;
            end else begin
                rd_data_reg <= ring_mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/swpc_intake.sv -----
// input register, window length register and sample position counter
// depends on swpc_pkg and the assertion macro header
`include "sliding_window_peak_counter_top_defines.svh"

module swpc_intake (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [swpc_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [swpc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           take,
    output logic                           item_valid,
    output swpc_pkg::item_t                item,
    output logic                           rd_en,
    output logic [swpc_pkg::RING_AW-1:0]   rd_addr
);

    logic [swpc_pkg::CFG_W-1:0]   win_len_reg;
    logic [swpc_pkg::INDEX_W-1:0] pos_reg;
    logic [swpc_pkg::INDEX_W-1:0] pos_next;
    logic                         in_valid_reg;
    logic                         in_valid_next;
    swpc_pkg::item_t              item_reg;
    swpc_pkg::item_t              item_next;
    logic [swpc_pkg::CFG_W-1:0]   k_eff;
    logic [swpc_pkg::INDEX_W-1:0] k_idx;
    logic                         pos_sat;
    logic                         accept;

    assign s_tready = !in_valid_reg || take;
    assign accept   = s_tvalid && s_tready;
    assign k_eff    = swpc_pkg::clamp_window(win_len_reg);
    assign k_idx    = swpc_pkg::INDEX_W'(k_eff);
    assign pos_sat  = (pos_reg == swpc_pkg::POS_MAX);

    // window bookkeeping for the incoming sample
    always_comb begin
        item_next.sample = s_tdata[swpc_pkg::SAMPLE_W-1:0];
        item_next.last   = s_tlast;
        item_next.skip   = pos_sat;
        item_next.pos    = pos_reg + swpc_pkg::INDEX_W'(1);
        item_next.full   = !pos_sat && (item_next.pos >= k_idx);
        item_next.left   = item_next.pos - k_idx + swpc_pkg::INDEX_W'(1);
    end

    // position counter restarts after the last sample of a sequence
    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            if (s_tlast) begin
                pos_next = '0;
            end else if (!pos_sat) begin
                pos_next = item_next.pos;
            end
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (take) begin
            in_valid_next = 1'b0;
        end
    end

    // look up the flag that leaves the window for this sample
    assign rd_en   = accept;
    assign rd_addr = item_next.left[swpc_pkg::RING_AW-1:0];

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg  <= swpc_pkg::WIN_RESET;
            pos_reg      <= '0;
            in_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                win_len_reg <= cfg_wr_data;
            end
            pos_reg      <= pos_next;
            in_valid_reg <= in_valid_next;
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = in_valid_reg;
    assign item       = item_reg;

    `SWPC_ASSERT_NEXT(a_pos_restart, aclk, aresetn, accept && s_tlast, pos_reg == '0,
        "position not restarted after last sample")
    `SWPC_ASSERT_NOW(a_pos_nonzero, aclk, aresetn, in_valid_reg && !item_reg.skip,
        item_reg.pos != '0, "held sample has position zero")
    `SWPC_ASSERT_NOW(a_window_inside, aclk, aresetn, in_valid_reg && item_reg.full,
        (item_reg.left != '0) && (item_reg.left < item_reg.pos),
        "window start not before window end")

endmodule

// ----- rtl/core/swpc_scan.sv -----
// peak detection, window peak count, best window tracking and result register
// depends on swpc_pkg and the assertion macro header
`include "sliding_window_peak_counter_top_defines.svh"

module swpc_scan (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           item_valid,
    input  swpc_pkg::item_t                item,
    input  logic                           flag_rd,
    output logic                           take,
    output swpc_pkg::flag_wr_t             flag_wr,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [swpc_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [swpc_pkg::SAMPLE_W-1:0] older_reg, older_next;
    logic [swpc_pkg::SAMPLE_W-1:0] newer_reg, newer_next;
    logic [swpc_pkg::COUNT_W-1:0]  wp_reg, wp_next;
    logic [swpc_pkg::COUNT_W-1:0]  best_reg, best_next;
    logic [swpc_pkg::INDEX_W-1:0]  bstart_reg, bstart_next;
    logic                          seen_reg, seen_next;
    logic                          ovf_reg, ovf_next;
    logic                          out_valid_reg, out_valid_next;
    logic [swpc_pkg::OUT_W-1:0]    out_data_reg, out_data_next;

    logic                          peak;
    logic [swpc_pkg::COUNT_W-1:0]  wp_inc;
    logic [swpc_pkg::COUNT_W-1:0]  wp_dec;
    logic                          res_valid;
    logic [swpc_pkg::COUNT_W-1:0]  res_segments;
    logic [swpc_pkg::INDEX_W-1:0]  res_start;

    // a last sample waits until the result register is free
    assign take = item_valid && (!item.last || !out_valid_reg || m_tready);

    // strict local peak at the previous sample
    assign peak = (item.pos >= swpc_pkg::INDEX_W'(3)) && (older_reg < newer_reg)
                  && (newer_reg > item.sample);

    always_comb begin
        flag_wr.en   = take && !item.skip && (item.pos >= swpc_pkg::INDEX_W'(2));
        flag_wr.addr = swpc_pkg::RING_AW'(item.pos - swpc_pkg::INDEX_W'(1));
        flag_wr.data = peak;
    end

    // count enters with the new peak and leaves with the window start
    assign wp_inc = (peak && (wp_reg != swpc_pkg::COUNT_CAP))
                    ? wp_reg + swpc_pkg::COUNT_W'(1) : wp_reg;
    assign wp_dec = (item.full && flag_rd && (wp_inc != '0))
                    ? wp_inc - swpc_pkg::COUNT_W'(1) : wp_inc;

    // sequence state update
    always_comb begin
        older_next  = older_reg;
        newer_next  = newer_reg;
        wp_next     = wp_reg;
        best_next   = best_reg;
        bstart_next = bstart_reg;
        seen_next   = seen_reg;
        ovf_next    = ovf_reg;
        if (take) begin
            if (item.skip) begin
                ovf_next = 1'b1;
            end else begin
                older_next = newer_reg;
                newer_next = item.sample;
                if (item.pos >= swpc_pkg::INDEX_W'(2)) begin
                    wp_next = wp_inc;
                end
                if (item.full) begin
                    wp_next = wp_dec;
                    if (!seen_reg || (wp_dec > best_reg)) begin
                        best_next   = wp_dec;
                        bstart_next = item.left;
                        seen_next   = 1'b1;
                    end
                end
            end
        end
    end

    // result fields from the updated state
    assign res_valid    = seen_next;
    assign res_segments = seen_next ? best_next + swpc_pkg::COUNT_W'(1) : '0;
    assign res_start    = seen_next ? bstart_next : '0;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (take && item.last) begin
            out_valid_next = 1'b1;
            out_data_next  = {ovf_next, res_start, res_segments, res_valid};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control and sequence registers, cleared at the end of each sequence
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            older_reg     <= '0;
            newer_reg     <= '0;
            wp_reg        <= '0;
            best_reg      <= '0;
            bstart_reg    <= '0;
            seen_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take && item.last) begin
                older_reg  <= '0;
                newer_reg  <= '0;
                wp_reg     <= '0;
                best_reg   <= '0;
                bstart_reg <= '0;
                seen_reg   <= 1'b0;
                ovf_reg    <= 1'b0;
            end else begin
                older_reg  <= older_next;
                newer_reg  <= newer_next;
                wp_reg     <= wp_next;
                best_reg   <= best_next;
                bstart_reg <= bstart_next;
                seen_reg   <= seen_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = swpc_pkg::M_TDATA_W'(out_data_reg);

    `SWPC_ASSERT_NEXT(a_seq_cleared, aclk, aresetn, take && item.last,
        (wp_reg == '0) && !seen_reg && !ovf_reg, "sequence state not cleared")
    `SWPC_ASSERT_NOW(a_best_unseen, aclk, aresetn, !seen_reg,
        (best_reg == '0) && (bstart_reg == '0), "best window set without a window")
    `SWPC_ASSERT_NOW(a_invalid_result, aclk, aresetn, out_valid_reg && !out_data_reg[0],
        out_data_reg[swpc_pkg::OUT_W-2:1] == '0, "invalid result carries data")

endmodule

// ----- rtl/core/sliding_window_peak_counter_top.sv -----
// an accepted sample is held in the input register until the scan takes it. throughput: one
// sample per cycle unless a last sample waits for the result register, set by the single flag
// ring read port and the one-stage count update. reset (aresetn low, synchronous) sets the
// window length to 3 and clears the sequence state; the flag ring needs no clearing pass, as
// every entry is written within a sequence before it is read.
// depends on swpc_pkg, swpc_intake, swpc_flag_ring, swpc_scan
module sliding_window_peak_counter_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [swpc_pkg::CFG_W-1:0]     cfg_wr_data,   // window_length
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [swpc_pkg::S_TDATA_W-1:0] s_tdata,       // [15:0] sample
    input  logic                           s_tlast,       // last
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] valid_res, [10:1] segments, [26:11] start_index, [27] overflow
    output logic [swpc_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                         take;
    logic                         item_valid;
    swpc_pkg::item_t              item;
    logic                         rd_en;
    logic [swpc_pkg::RING_AW-1:0] rd_addr;
    logic                         flag_rd;
    swpc_pkg::flag_wr_t           flag_wr;

    // sample intake and window bookkeeping
    swpc_intake u_intake (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .take        (take),
        .item_valid  (item_valid),
        .item        (item),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr)
    );

    // peak flags of the current window
    swpc_flag_ring u_ring (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr      (flag_wr),
        .rd_data (flag_rd)
    );

    // counting and result
    swpc_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .flag_rd    (flag_rd),
        .take       (take),
        .flag_wr    (flag_wr),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
